>>> rtl/smpq_pkg.sv
// Shared types, codes and defaults for the sorted max-priority queue.
package smpq_pkg;

	localparam int DefCapacity = 16;
	localparam int ValueWidth  = 32;
	localparam int OccWidth    = 5;

	typedef logic signed [ValueWidth-1:0] value_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic   insert_en;
		logic   remove_en;
		value_t new_value;
	} cell_ctl_t;

endpackage

>>> rtl/smpq_cell.sv
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module smpq_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                 clk,
	input  smpq_pkg::cell_ctl_t  ctl,
	input  logic [CNT_W-1:0]     count,
	input  smpq_pkg::value_t     prev_value,
	input  logic                 prev_go,
	input  smpq_pkg::value_t     next_value,
	output smpq_pkg::value_t     value,
	output logic                 go
);

	smpq_pkg::value_t value_q;
	logic             occupied;

	assign occupied = count > CNT_W'(INDEX);

	// Strictly greater: a new value lands behind stored values equal to it.
	assign go    = !occupied || (ctl.new_value > value_q);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.insert_en && go) begin
			value_q <= prev_go ? prev_value : ctl.new_value;
		end else if (ctl.remove_en) begin
			value_q <= next_value;
		end
	end

endmodule

>>> rtl/sorted_max_priority_queue_top.sv
// Top level of the sorted max-priority queue: cell chain, count and result register.
//
// Max-priority queue of signed 32-bit values held as a chain of CAPACITY
// cells kept in descending order, largest in cell 0. An insert is broadcast
// to all cells at once: each cell compares the new value with its own,
// and every cell from the insertion point on takes its left neighbor's value
// (the first of them takes the new value), so a value goes after any stored
// equal values. A remove shifts every cell one place toward cell 0 and
// returns what cell 0 held. Each accepted item yields exactly one result in
// the following cycle with removed_value, status and the occupancy after the item.
// Remove from an empty queue returns 0 with status 1; insert into a full
// queue is dropped with status 2. Throughput is one item per cycle: the
// chain updates in the accepting cycle and the result sits in a single
// output register, so input stalls only while that register holds a result
// the consumer is stalling. Occupancy is reported in 5 bits, masked when
// CAPACITY exceeds 31. No clearing pass is needed after reset.
module sorted_max_priority_queue_top #(
	parameter int CAPACITY = smpq_pkg::DefCapacity
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic signed [smpq_pkg::ValueWidth-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [smpq_pkg::ValueWidth-1:0] removed_value,
	output logic [1:0]                          status,
	output logic [smpq_pkg::OccWidth-1:0]       occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	smpq_pkg::cell_ctl_t ctl;
	smpq_pkg::value_t    cell_value [CAPACITY];
	logic                cell_go    [CAPACITY];

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic                accept;
	logic                is_remove;
	logic                full;
	logic                empty;

	logic                out_valid_q;
	smpq_pkg::value_t    removed_q;
	smpq_pkg::status_t   status_q;
	logic [smpq_pkg::OccWidth-1:0] occupancy_q;

	// Hold input while a finished result waits on a stalled consumer.
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign is_remove = operation == smpq_pkg::OP_REMOVE;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;

	assign ctl.insert_en = accept && !is_remove && !full;
	assign ctl.remove_en = accept && is_remove && !empty;
	assign ctl.new_value = value;

	always_comb begin
		count_next = count_q;
		if (ctl.insert_en) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.remove_en) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// Chain of cells; the ends see the new value on the left and themselves on the right.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smpq_pkg::value_t prev_v;
		smpq_pkg::value_t next_v;
		logic             prev_g;

		if (i == 0) begin : g_head
			assign prev_v = value;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_v = cell_value[i-1];
			assign prev_g = cell_go[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_v = cell_value[i];
		end else begin : g_body
			assign next_v = cell_value[i+1];
		end

		smpq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.prev_value (prev_v),
			.prev_go    (prev_g),
			.next_value (next_v),
			.value      (cell_value[i]),
			.go         (cell_go[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			// Advance the result register on accept, drop it once taken.
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q   <= ctl.remove_en ? cell_value[0] : '0;
			occupancy_q <= smpq_pkg::OccWidth'(count_next);
			if (is_remove && empty) begin
				status_q <= smpq_pkg::ST_EMPTY;
			end else if (!is_remove && full) begin
				status_q <= smpq_pkg::ST_FULL;
			end else begin
				status_q <= smpq_pkg::ST_OK;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign occupancy     = occupancy_q;

endmodule
